### design/gbn_pkg.sv
// gbn_pkg: field widths, kept-list entry type, scan status and sequencer states
// shared by the greedy box nms block and its interfaces-free submodules
// depends on: nothing
package gbn_pkg;

    localparam int COORD_W = 16;   // signed box edge
    localparam int EDGE_W  = 17;   // signed edge plus extent
    localparam int EXT_W   = 15;   // unsigned width or height
    localparam int CLASS_W = 8;
    localparam int AREA_W  = 30;   // extent times extent
    localparam int UNION_W = 31;   // sum of two areas
    localparam int THR_W   = 9;
    localparam int PROD_W  = 40;   // threshold times union
    localparam int SLOT_W  = 6;

    localparam logic [THR_W-1:0] THR_RESET = 9'd115;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [EDGE_W-1:0]  right;
        logic signed [EDGE_W-1:0]  bottom;
        logic [CLASS_W-1:0]        cls;
        logic [AREA_W-1:0]         area;
    } kept_entry_t;

    typedef struct packed {
        logic busy;   // compares still in flight
        logic hit;    // some kept box suppresses the current one
    } scan_status_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PREP  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

### design/gbn_ifs.sv
// gbn_box_if and gbn_res_if: valid/ready channels for box requests and verdicts
// depends on: nothing
interface gbn_box_if;
    logic              valid;
    logic              ready;
    logic              start_set;
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic [14:0]       box_width;
    logic [14:0]       box_height;
    logic [7:0]        class_id;

    modport source (
        output valid, start_set, box_left, box_top, box_width, box_height, class_id,
        input  ready
    );
    modport sink (
        input  valid, start_set, box_left, box_top, box_width, box_height, class_id,
        output ready
    );
endinterface

interface gbn_res_if;
    logic       valid;
    logic       ready;
    logic       keep;
    logic [5:0] kept_slot;
    logic       list_overflow;

    modport source (
        output valid, keep, kept_slot, list_overflow,
        input  ready
    );
    modport sink (
        input  valid, keep, kept_slot, list_overflow,
        output ready
    );
endinterface

### design/gbn_kept_mem.sv
// gbn_kept_mem: kept-box list storage, one write port and one registered read port
// depends on: gbn_pkg
module gbn_kept_mem #(
    parameter int DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  gbn_pkg::kept_entry_t        wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output gbn_pkg::kept_entry_t        rd_data
);

    gbn_pkg::kept_entry_t mem [DEPTH];
    gbn_pkg::kept_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/gbn_iou_unit.sv
// gbn_iou_unit: pipelined overlap compare of the current box against one kept
// entry per cycle, folding the suppress decisions into one hit flag
// depends on: gbn_pkg
module gbn_iou_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                issue,
    input  logic                                clear,
    input  gbn_pkg::kept_entry_t                entry,
    input  gbn_pkg::kept_entry_t                probe,
    input  logic [gbn_pkg::THR_W-1:0]           threshold,
    output gbn_pkg::scan_status_t               status
);

    // valid bits: read data, extents, intersection, union, product
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic hit_reg;

    // stage 2
    logic [gbn_pkg::EXT_W-1:0]  iw_reg, ih_reg;
    logic                       match2_reg;
    logic [gbn_pkg::AREA_W-1:0] karea2_reg;
    // stage 3
    logic [gbn_pkg::AREA_W-1:0] inter3_reg, karea3_reg;
    logic                       match3_reg;
    // stage 4
    logic [gbn_pkg::AREA_W-1:0]  inter4_reg;
    logic [gbn_pkg::UNION_W-1:0] uni4_reg;
    logic                        match4_reg;
    // stage 5
    logic [gbn_pkg::PROD_W-1:0] lhs5_reg, rhs5_reg;
    logic                       live5_reg;

    logic signed [gbn_pkg::COORD_W-1:0] max_l, max_t;
    logic signed [gbn_pkg::EDGE_W-1:0]  min_r, min_b;
    logic signed [gbn_pkg::EDGE_W:0]    iw, ih;
    logic                               overlap;
    logic [gbn_pkg::UNION_W-1:0]        uni;

    always_comb
    begin
        max_l = (probe.left > entry.left) ? probe.left : entry.left;
        max_t = (probe.top > entry.top) ? probe.top : entry.top;
        min_r = (probe.right < entry.right) ? probe.right : entry.right;
        min_b = (probe.bottom < entry.bottom) ? probe.bottom : entry.bottom;
        iw = {min_r[gbn_pkg::EDGE_W-1], min_r} - {{2{max_l[gbn_pkg::COORD_W-1]}}, max_l};
        ih = {min_b[gbn_pkg::EDGE_W-1], min_b} - {{2{max_t[gbn_pkg::COORD_W-1]}}, max_t};
        // a positive overlap never exceeds either extent, so 15 bits hold it
        overlap = !iw[gbn_pkg::EDGE_W] && (iw != '0) && !ih[gbn_pkg::EDGE_W] && (ih != '0);
        uni = {1'b0, probe.area} + {1'b0, karea3_reg} - {1'b0, inter3_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (clear)
            begin
                hit_reg <= 1'b0;
            end
            else if (v5_reg && live5_reg && (lhs5_reg > rhs5_reg))
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        iw_reg     <= overlap ? iw[gbn_pkg::EXT_W-1:0] : '0;
        ih_reg     <= overlap ? ih[gbn_pkg::EXT_W-1:0] : '0;
        match2_reg <= (probe.cls == entry.cls);
        karea2_reg <= entry.area;

        inter3_reg <= iw_reg * ih_reg;
        karea3_reg <= karea2_reg;
        match3_reg <= match2_reg;

        inter4_reg <= inter3_reg;
        uni4_reg   <= uni;
        match4_reg <= match3_reg;

        // zero union never suppresses
        lhs5_reg  <= {2'b00, inter4_reg, 8'h00};
        rhs5_reg  <= threshold * uni4_reg;
        live5_reg <= match4_reg && (uni4_reg != '0);
    end

    assign status.busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign status.hit  = hit_reg;

endmodule

### design/greedy_box_nms.sv
// greedy_box_nms: top level of the class-aware greedy non-maximum suppression block
// depends on: gbn_pkg, gbn_ifs (gbn_box_if, gbn_res_if), gbn_kept_mem, gbn_iou_unit

// Boxes come in already sorted by falling score, one request per box, and each
// gets exactly one verdict. A box is checked against every box in the kept list
// of the same class; it is dropped when intersection*256 > iou_threshold*union
// (a zero union never drops, a threshold of 256 or more never drops). A survivor
// is appended and its list slot reported; when the list already holds MAX_KEPT
// boxes it is reported kept with list_overflow set and not stored. start_set on
// a request empties the list before that box is checked. A box passes through
// these steps: area setup, one kept entry read from the list memory and fed to
// the pipelined overlap unit per cycle, a step to see the end of the list, a
// drain of the read and compare stages and a step to publish the verdict and
// append the survivor. A verdict that is not taken holds the sequencer in its
// last step. boxes.ready is high only while the sequencer is idle; a finished
// verdict sits in an output register so the next box can be taken before it is
// consumed. iou_threshold resets to 115 and should only be written while no box
// is in flight. The list memory needs no clearing after reset.
module greedy_box_nms #(
    parameter int MAX_KEPT = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    gbn_box_if.sink                   boxes,
    gbn_res_if.source                 verdicts,
    input  logic                      cfg_wr_en,
    input  logic [gbn_pkg::THR_W-1:0] cfg_wr_data
);

    localparam int ADDR_W = $clog2(MAX_KEPT);
    localparam int CNT_W  = $clog2(MAX_KEPT + 1);

    // sequencer
    gbn_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;       // next kept entry to read
    logic [CNT_W-1:0] count_reg, count_next;   // kept list fill

    logic [gbn_pkg::THR_W-1:0] thr_reg;

    // current box
    gbn_pkg::kept_entry_t      box_reg;
    logic [gbn_pkg::EXT_W-1:0] w_reg, h_reg;

    // verdict register
    logic                      out_valid_reg;
    logic                      keep_reg;
    logic [gbn_pkg::SLOT_W-1:0] slot_reg;
    logic                      ovf_reg;

    logic accept;
    logic issue;
    logic scan_clear;
    logic publish;
    logic mem_we;
    logic not_full;
    logic keep_now;
    logic [CNT_W+gbn_pkg::SLOT_W-1:0] slot_wide;

    gbn_pkg::kept_entry_t  rd_entry;
    gbn_pkg::scan_status_t scan_status;

    assign accept    = boxes.valid && boxes.ready;
    assign not_full  = (count_reg < CNT_W'(MAX_KEPT));
    assign keep_now  = !scan_status.hit;
    assign slot_wide = {{gbn_pkg::SLOT_W{1'b0}}, count_reg};

    assign boxes.ready = (state_reg == gbn_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        issue      = 1'b0;
        scan_clear = 1'b0;
        publish    = 1'b0;
        mem_we     = 1'b0;
        unique case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = gbn_pkg::ST_PREP;
                    if (boxes.start_set)
                    begin
                        count_next = '0;
                    end
                end
            end
            gbn_pkg::ST_PREP:
            begin
                // area is formed here, hit flag cleared before the sweep
                idx_next   = '0;
                scan_clear = 1'b1;
                state_next = gbn_pkg::ST_SCAN;
            end
            gbn_pkg::ST_SCAN:
            begin
                // one kept entry into the compare pipeline per cycle
                if (idx_reg == count_reg)
                begin
                    state_next = gbn_pkg::ST_DRAIN;
                end
                else
                begin
                    issue    = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            gbn_pkg::ST_DRAIN:
            begin
                if (!scan_status.busy)
                begin
                    state_next = gbn_pkg::ST_DONE;
                end
            end
            gbn_pkg::ST_DONE:
            begin
                // wait for room in the verdict register, then append survivor
                if (!out_valid_reg || verdicts.ready)
                begin
                    publish    = 1'b1;
                    state_next = gbn_pkg::ST_IDLE;
                    if (keep_now && not_full)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = gbn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbn_pkg::ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            thr_reg       <= gbn_pkg::THR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (verdicts.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            box_reg.left   <= boxes.box_left;
            box_reg.top    <= boxes.box_top;
            box_reg.right  <= $signed({boxes.box_left[gbn_pkg::COORD_W-1], boxes.box_left})
                            + $signed({2'b00, boxes.box_width});
            box_reg.bottom <= $signed({boxes.box_top[gbn_pkg::COORD_W-1], boxes.box_top})
                            + $signed({2'b00, boxes.box_height});
            box_reg.cls    <= boxes.class_id;
            w_reg          <= boxes.box_width;
            h_reg          <= boxes.box_height;
        end
        if (state_reg == gbn_pkg::ST_PREP)
        begin
            box_reg.area <= w_reg * h_reg;
        end
        if (publish)
        begin
            // suppressed box: slot and overflow stay zero
            keep_reg <= keep_now;
            slot_reg <= (keep_now && not_full) ? slot_wide[gbn_pkg::SLOT_W-1:0] : '0;
            ovf_reg  <= keep_now && !not_full;
        end
    end

    assign verdicts.valid         = out_valid_reg;
    assign verdicts.keep          = keep_reg;
    assign verdicts.kept_slot     = slot_reg;
    assign verdicts.list_overflow = ovf_reg;

    gbn_kept_mem #(
        .DEPTH (MAX_KEPT)
    ) u_kept_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (box_reg),
        .rd_en   (issue),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_entry)
    );

    gbn_iou_unit u_iou_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .clear     (scan_clear),
        .entry     (rd_entry),
        .probe     (box_reg),
        .threshold (thr_reg),
        .status    (scan_status)
    );

endmodule

### dv/tb_greedy_box_nms.sv
// tb_greedy_box_nms: self-checking bench for the greedy class-aware box nms block
// holds a box-by-box verdict predictor, a directed table, framed random boxes and config phases
// depends on: gbn_pkg, gbn_ifs (gbn_box_if, gbn_res_if), greedy_box_nms
module tb_greedy_box_nms;

    // kept list depth of the instance under test
    localparam int KEPT_DEPTH     = 64;
    // random boxes per threshold setting, seven settings in all
    localparam int BOXES_PER_SET  = 68;
    localparam int HOLD_CYCLES    = 250;
    // long enough to cover a full-list scan of any box in flight
    localparam int SETTLE_CYCLES  = 90;
    localparam int MAX_REPORTS    = 40;
    localparam int N_DIRECTED     = 18;
    // room for the verdicts owed at any one time
    localparam int OWED_DEPTH     = 16;

    typedef struct packed {
        logic                               start;
        logic signed [gbn_pkg::COORD_W-1:0] left;
        logic signed [gbn_pkg::COORD_W-1:0] top;
        logic [gbn_pkg::EXT_W-1:0]          width;
        logic [gbn_pkg::EXT_W-1:0]          height;
        logic [gbn_pkg::CLASS_W-1:0]        cls;
    } box_req_t;

    typedef struct packed {
        logic                       keep;
        logic [gbn_pkg::SLOT_W-1:0] slot;
        logic                       overflow;
    } verdict_t;

    // one row of the directed table; typed rows carry a verdict written by hand
    typedef struct packed {
        box_req_t req;
        logic     typed;
        verdict_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic                      cfg_wr_en;
    logic [gbn_pkg::THR_W-1:0] cfg_wr_data;

    gbn_box_if box_bus ();
    gbn_res_if verdict_bus ();

    greedy_box_nms #(
        .MAX_KEPT (KEPT_DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .boxes       (box_bus),
        .verdicts    (verdict_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // predictor state: our own copy of the kept list and the threshold
    // ------------------------------------------------------------------
    logic [gbn_pkg::THR_W-1:0]          thr_now;
    logic signed [gbn_pkg::COORD_W-1:0] list_left   [KEPT_DEPTH];
    logic signed [gbn_pkg::COORD_W-1:0] list_top    [KEPT_DEPTH];
    logic signed [gbn_pkg::EDGE_W-1:0]  list_right  [KEPT_DEPTH];
    logic signed [gbn_pkg::EDGE_W-1:0]  list_bottom [KEPT_DEPTH];
    logic [gbn_pkg::CLASS_W-1:0]        list_cls    [KEPT_DEPTH];
    logic [gbn_pkg::AREA_W-1:0]         list_area   [KEPT_DEPTH];
    int                                 list_count;

    // verdicts owed by the block, oldest at owed_head
    verdict_t owed_verdicts [OWED_DEPTH];
    int       owed_head;
    int       owed_tail;

    // bookkeeping for the summary and the final verdict
    int mismatch_count;
    int boxes_sent;
    int kept_total;
    int suppressed_total;
    int full_total;
    int verdicts_checked;
    int settings_used;

    // sender pacing and receiver hold-off request
    int burst_left;
    bit hold_req;

    // directed table, all at the reset threshold of 115
    dir_row_t directed_rows [N_DIRECTED] = '{
        // largest box at the most negative corner into an empty list
        '{'{1'b1, 16'sh8000, 16'sh8000, 15'd32767, 15'd32767, 8'd0},   1'b1, '{1'b1, 6'd0, 1'b0}},
        // identical box, same class: full overlap, dropped
        '{'{1'b0, 16'sh8000, 16'sh8000, 15'd32767, 15'd32767, 8'd0},   1'b1, '{1'b0, 6'd0, 1'b0}},
        // identical box, other class: never compared
        '{'{1'b0, 16'sh8000, 16'sh8000, 15'd32767, 15'd32767, 8'd255}, 1'b1, '{1'b1, 6'd1, 1'b0}},
        // far corner, no overlap with anything
        '{'{1'b0, 16'sh7FFF, 16'sh7FFF, 15'd32767, 15'd32767, 8'd0},   1'b1, '{1'b1, 6'd2, 1'b0}},
        // zero-area box, new class
        '{'{1'b0, 16'sh0000, 16'sh0000, 15'd0,     15'd0,     8'd7},   1'b1, '{1'b1, 6'd3, 1'b0}},
        // same zero-area box again: union is zero, never dropped
        '{'{1'b0, 16'sh0000, 16'sh0000, 15'd0,     15'd0,     8'd7},   1'b1, '{1'b1, 6'd4, 1'b0}},
        // zero width but some height, still a zero union
        '{'{1'b0, 16'sh0000, 16'sh0000, 15'd0,     15'd100,   8'd7},   1'b1, '{1'b1, 6'd5, 1'b0}},
        // start flag empties the list
        '{'{1'b1, 16'sh0000, 16'sh0000, 15'd160,   15'd160,   8'd3},   1'b1, '{1'b1, 6'd0, 1'b0}},
        // heavy overlap, light overlap, other class, touching edge
        '{'{1'b0, 16'sh0010, 16'sh0000, 15'd160,   15'd160,   8'd3},   1'b0, '0},
        '{'{1'b0, 16'sh0050, 16'sh0000, 15'd160,   15'd160,   8'd3},   1'b0, '0},
        '{'{1'b0, 16'sh0000, 16'sh0000, 15'd160,   15'd160,   8'd4},   1'b0, '0},
        '{'{1'b0, 16'sh00A0, 16'sh0000, 15'd160,   15'd160,   8'd3},   1'b0, '0},
        // enclosing box and an exact repeat
        '{'{1'b0, 16'shFFF8, 16'shFFF8, 15'd176,   15'd176,   8'd3},   1'b0, '0},
        '{'{1'b0, 16'sh0000, 16'sh0000, 15'd160,   15'd160,   8'd3},   1'b0, '0},
        // flat box at the field extremes after a fresh start
        '{'{1'b1, 16'sh8000, 16'sh7FFF, 15'd32767, 15'd0,     8'd128}, 1'b1, '{1'b1, 6'd0, 1'b0}},
        '{'{1'b0, 16'sh7FFF, 16'sh8000, 15'd0,     15'd32767, 8'd128}, 1'b0, '0},
        // alternating bit patterns
        '{'{1'b0, 16'sh5555, 16'sh2AAA, 15'h2AAA,  15'h5555,  8'hAA},  1'b0, '0},
        '{'{1'b0, 16'shAAAA, 16'shD555, 15'h5555,  15'h2AAA,  8'h55},  1'b0, '0}
    };

    // ------------------------------------------------------------------
    // clock and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit, set well beyond what a correct run needs
    initial
    begin
        #(8 * 500000);
        $display("timeout with %0d verdicts still owed", owed_tail - owed_head);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor: verdict for one box, updates the kept list copy
    // ------------------------------------------------------------------
    function automatic verdict_t nms_verdict(input box_req_t b);
        verdict_t v;
        int       l, t, r, btm, ext_w, ext_h;
        int       iw, ih;
        longint   area, inter, uni;
        bit       dropped;

        l       = b.left;
        t       = b.top;
        ext_w   = b.width;
        ext_h   = b.height;
        r       = l + ext_w;
        btm     = t + ext_h;
        area    = longint'(ext_w) * longint'(ext_h);
        dropped = 1'b0;

        if (b.start)
            list_count = 0;

        // greedy scan: first same-class kept box that overlaps too much wins
        for (int i = 0; i < list_count; i++)
        begin
            if (list_cls[i] != b.cls)
                continue;
            iw    = ((r < int'(list_right[i])) ? r : int'(list_right[i]))
                  - ((l > int'(list_left[i])) ? l : int'(list_left[i]));
            ih    = ((btm < int'(list_bottom[i])) ? btm : int'(list_bottom[i]))
                  - ((t > int'(list_top[i])) ? t : int'(list_top[i]));
            inter = (iw > 0 && ih > 0) ? longint'(iw) * longint'(ih) : 0;
            uni   = area + longint'(list_area[i]) - inter;
            if (uni != 0 && inter * 256 > longint'(thr_now) * uni)
            begin
                dropped = 1'b1;
                break;
            end
        end

        v = '0;
        if (dropped)
            suppressed_total++;
        else if (list_count < KEPT_DEPTH)
        begin
            v.keep                  = 1'b1;
            v.slot                  = list_count[gbn_pkg::SLOT_W-1:0];
            list_left[list_count]   = b.left;
            list_top[list_count]    = b.top;
            list_right[list_count]  = r[gbn_pkg::EDGE_W-1:0];
            list_bottom[list_count] = btm[gbn_pkg::EDGE_W-1:0];
            list_cls[list_count]    = b.cls;
            list_area[list_count]   = area[gbn_pkg::AREA_W-1:0];
            list_count++;
            kept_total++;
        end
        else
        begin
            // list already full: survivor reported but not stored
            v.keep     = 1'b1;
            v.overflow = 1'b1;
            full_total++;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // sender: offer one box request, wait for the handshake, log the verdict owed
    // called and returning just after a rising edge
    // ------------------------------------------------------------------
    task automatic send_box(input box_req_t b, input bit typed, input verdict_t typed_want);
        verdict_t predicted;
        box_bus.valid      <= 1'b1;
        box_bus.start_set  <= b.start;
        box_bus.box_left   <= b.left;
        box_bus.box_top    <= b.top;
        box_bus.box_width  <= b.width;
        box_bus.box_height <= b.height;
        box_bus.class_id   <= b.cls;
        do
            @(posedge clk);
        while (!(box_bus.valid && box_bus.ready));
        // the predictor always runs so its list stays in step with the block
        predicted = nms_verdict(b);
        owed_verdicts[owed_tail % OWED_DEPTH] = typed ? typed_want : predicted;
        owed_tail++;
        boxes_sent++;
    endtask

    // bursts of back-to-back requests, then a random gap; a zero gap leaves valid alone
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0)
        begin
            box_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // write the threshold only once the block has nothing in flight
    task automatic set_threshold(input logic [gbn_pkg::THR_W-1:0] value);
        box_bus.valid <= 1'b0;
        while (owed_tail != owed_head)
            @(posedge clk);
        repeat (12) @(posedge clk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        thr_now     = value;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // receiver: own ready pattern, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int rx_mode;
        int mode_left;
        rx_mode   = 0;
        mode_left = 0;
        verdict_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                verdict_bus.ready <= 1'b0;
            else if (hold_req)
            begin
                // long stall so the output register fills and boxes.ready drops
                hold_req = 1'b0;
                verdict_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (rx_mode)
                    0, 1:    verdict_bus.ready <= 1'b1;
                    2:       verdict_bus.ready <= 1'($urandom_range(0, 1));
                    default: verdict_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // verdict checker: every accepted verdict against the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && verdict_bus.valid && verdict_bus.ready)
        begin
            if (owed_tail == owed_head)
                report_mismatch($sformatf("verdict keep=%0d slot=%0d overflow=%0d with none owed",
                                          verdict_bus.keep, verdict_bus.kept_slot,
                                          verdict_bus.list_overflow));
            else
            begin
                want = owed_verdicts[owed_head % OWED_DEPTH];
                owed_head++;
                if (verdict_bus.keep !== want.keep)
                    report_mismatch($sformatf("verdict %0d keep=%0d, want %0d",
                                              verdicts_checked, verdict_bus.keep, want.keep));
                if (verdict_bus.kept_slot !== want.slot)
                    report_mismatch($sformatf("verdict %0d kept_slot=%0d, want %0d",
                                              verdicts_checked, verdict_bus.kept_slot, want.slot));
                if (verdict_bus.list_overflow !== want.overflow)
                    report_mismatch($sformatf("verdict %0d list_overflow=%0d, want %0d",
                                              verdicts_checked, verdict_bus.list_overflow,
                                              want.overflow));
            end
            verdicts_checked++;
        end
    end

    // ------------------------------------------------------------------
    // main sequence: reset, directed table, then framed random boxes per threshold
    // ------------------------------------------------------------------
    initial
    begin
        logic [gbn_pkg::THR_W-1:0] thr_plan [7];
        box_req_t                  b;
        int                        sent_in_set;
        int                        frame_len;
        int                        cx, cy, cls_base, cls_spread;
        bit                        big_frame;

        thr_now          = gbn_pkg::THR_RESET;
        list_count       = 0;
        mismatch_count   = 0;
        boxes_sent       = 0;
        kept_total       = 0;
        suppressed_total = 0;
        full_total       = 0;
        verdicts_checked = 0;
        settings_used    = 1;
        burst_left       = 0;
        hold_req         = 1'b0;

        // threshold extremes, both sides of 256, and one random pick
        thr_plan = '{9'd0, 9'd511, 9'd256, 9'd255, 9'd1,
                     9'($urandom_range(2, 254)), 9'd128};

        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        box_bus.valid      <= 1'b0;
        box_bus.start_set  <= 1'b0;
        box_bus.box_left   <= '0;
        box_bus.box_top    <= '0;
        box_bus.box_width  <= '0;
        box_bus.box_height <= '0;
        box_bus.class_id   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part runs on the reset threshold
        foreach (directed_rows[i])
        begin
            send_box(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
            pace_sender();
        end

        foreach (thr_plan[s])
        begin
            set_threshold(thr_plan[s]);
            sent_in_set = 0;
            while (sent_in_set < BOXES_PER_SET)
            begin
                // a frame: start flag on the first box unless it is noise, then a cluster of boxes
                big_frame  = ($urandom_range(0, 9) == 0);
                frame_len  = big_frame ? $urandom_range(66, 72) : $urandom_range(1, 24);
                cx         = int'($urandom_range(0, 8000)) - 4000;
                cy         = int'($urandom_range(0, 8000)) - 4000;
                cls_base   = $urandom_range(0, 255);
                cls_spread = $urandom_range(0, 2);
                for (int k = 0; k < frame_len; k++)
                begin
                    if (!big_frame && $urandom_range(0, 4) == 0)
                    begin
                        // noise: any field value, stray start flags
                        b.start  = ($urandom_range(0, 7) == 0);
                        b.left   = 16'($urandom());
                        b.top    = 16'($urandom());
                        b.width  = 15'($urandom());
                        b.height = 15'($urandom());
                        b.cls    = 8'($urandom());
                    end
                    else
                    begin
                        b.start  = (k == 0);
                        b.left   = 16'(cx + int'($urandom_range(0, 128)) - 64);
                        b.top    = 16'(cy + int'($urandom_range(0, 128)) - 64);
                        b.width  = 15'($urandom_range(48, 400));
                        b.height = 15'($urandom_range(48, 400));
                        // big frames use distinct classes so the list runs full
                        if (big_frame)
                            b.cls = 8'(cls_base + k);
                        else
                            b.cls = 8'(cls_base + $urandom_range(0, cls_spread));
                    end
                    send_box(b, 1'b0, '0);
                    sent_in_set++;
                    // long output stall while requests keep coming, twice in the run
                    if ((s == 1 || s == 4) && sent_in_set == 30)
                        hold_req = 1'b1;
                    pace_sender();
                end
            end
        end

        box_bus.valid <= 1'b0;
        while (owed_tail != owed_head)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d boxes: %0d kept, %0d suppressed, %0d kept past a full list",
                 boxes_sent, kept_total, suppressed_total, full_total);
        $display("%0d verdicts checked over %0d threshold settings, %0d mismatches",
                 verdicts_checked, settings_used, mismatch_count);
        if (mismatch_count == 0 && owed_tail == owed_head)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
